/* rtl/core/lru_key_value_cache_assert.svh */
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, off while rst is high.
`define LKVC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while rst is high.
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lkvc_pkg.sv */
package lkvc_pkg;

  localparam int ENTRIES   = 16;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int CAP_W     = 5;
  localparam int CAP_RESET = 16;
  localparam int RANK_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W     = $clog2(ENTRIES + 1);
  localparam int CMP_W     = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 3;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              clear;
    logic              lookup;
    logic              update;
    logic              put;
    logic              hit;
    logic              evict;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  wval;
    logic [RANK_W-1:0] hit_rank;
    logic [RANK_W-1:0] lru_rank;
  } cmd_t;

  // handed from cell i to cell i+1
  typedef struct packed {
    logic              hit;
    logic              found_free;
    logic [RANK_W-1:0] rank;
    logic [VAL_W-1:0]  value;
  } link_t;

  typedef struct packed {
    logic valid;
    logic match;
  } stat_t;

endpackage

/* rtl/core/lkvc_cell.sv */
module lkvc_cell (
  input  logic            clk,
  input  logic            rst,
  input  lkvc_pkg::cmd_t  cmd,
  input  lkvc_pkg::link_t link_in,
  output lkvc_pkg::link_t link_out,
  output lkvc_pkg::stat_t stat
);
  import lkvc_pkg::*;

  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;
  logic [RANK_W-1:0] rank;
  logic              valid;
  logic              match;
  logic              target_free;
  logic              lru;
  logic              target;

  // OR-reduce the single matching entry along the row; first free slot wins
  always_comb begin
    link_out.hit        = link_in.hit | match;
    link_out.rank       = link_in.rank | (match ? rank : '0);
    link_out.value      = link_in.value | (match ? value : '0);
    link_out.found_free = link_in.found_free | ~valid;
    target_free         = ~valid & ~link_in.found_free;
    lru                 = valid & (rank == cmd.lru_rank);
    target              = cmd.evict ? lru : target_free;
    stat.valid          = valid;
    stat.match          = match;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid <= 1'b0;
      match <= 1'b0;
      rank  <= '0;
    end else if (cmd.lookup) begin
      match <= valid & (key == cmd.key);
    end else if (cmd.update) begin
      if (cmd.hit) begin
        if (match) begin
          rank <= '0;
          if (cmd.put) begin
            value <= cmd.wval;
          end
        end else if (valid && (rank < cmd.hit_rank)) begin
          rank <= rank + RANK_W'(1);
        end
      end else if (cmd.put) begin
        if (target) begin
          key   <= cmd.key;
          value <= cmd.wval;
          valid <= 1'b1;
          rank  <= '0;
        end else if (valid) begin
          rank <= rank + RANK_W'(1);
        end
      end
    end
  end

endmodule

/* rtl/core/lru_key_value_cache.sv */
// LRU key-value cache, fully associative, 16 entries.
// A request passes the match state, the update state, then the result register, which raises done.
// Each request uses the cell row for a match, then an update; the next may enter during the update.
// busy is high only in the match cycle; start is taken again during the update cycle.
// Reset: store empty, capacity 16; a capacity write also empties it.
// Results last one cycle on done; the receiver cannot stall.
module lru_key_value_cache (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind,
  input  logic [lkvc_pkg::KEY_W-1:0]   key,
  input  logic [lkvc_pkg::VAL_W-1:0]   write_value,
  output logic                         done,
  output logic                         hit,
  output logic [lkvc_pkg::VAL_W-1:0]   read_value,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lkvc_pkg::PADDR_W-1:0] paddr,
  input  logic [lkvc_pkg::DATA_W-1:0]  pwdata,
  output logic [lkvc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import lkvc_pkg::*;

  `include "lru_key_value_cache_assert.svh"

  state_t            state;
  state_t            state_next;
  logic              accept;
  logic              cfg_write;
  logic [CAP_W-1:0]  capacity;
  logic [OCC_W-1:0]  occupancy;
  logic [OCC_W-1:0]  occ_m1;
  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  cap_eff;
  logic              full;
  logic              req_kind;
  logic [KEY_W-1:0]  req_key;
  logic [VAL_W-1:0]  req_wval;
  cmd_t              cmd;
  link_t             link [ENTRIES+1];
  stat_t             stat [ENTRIES];
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES-1:0] match_vec;
  logic              hit_now;
  logic              insert;

  // --- configuration port: single register, no wait states ---
  // writes with paddr[2] set are dropped and leave the store alone
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == REG_CAPACITY);
  assign prdata    = (paddr[2] == REG_CAPACITY) ? DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(CAP_RESET);
    end else if (cfg_write && (paddr[2] == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // zero means one; clamp to the number of cells
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
    full   = CMP_W'(occupancy) >= cap_eff;
    occ_m1 = occupancy - OCC_W'(1);
  end

  // --- sequencer ---
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        busy       = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        // next request may enter while this one commits
        state_next = start ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= kind;
      req_key  <= key;
      req_wval <= write_value;
    end
  end

  // --- cell row ---
  assign hit_now = link[ENTRIES].hit;
  assign insert  = (state == ST_UPDATE) && (req_kind == KIND_PUT) && !hit_now;

  always_comb begin
    cmd.clear    = cfg_write;
    cmd.lookup   = (state == ST_LOOKUP);
    cmd.update   = (state == ST_UPDATE);
    cmd.put      = (req_kind == KIND_PUT);
    cmd.hit      = hit_now;
    cmd.evict    = full;
    cmd.key      = req_key;
    cmd.wval     = req_wval;
    cmd.hit_rank = link[ENTRIES].rank;
    cmd.lru_rank = occ_m1[RANK_W-1:0];
  end

  assign link[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkvc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .stat     (stat[i])
    );
    assign valid_vec[i] = stat[i].valid;
    assign match_vec[i] = stat[i].match;
  end

  // occupancy grows only on an insert into a free cell
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      occupancy <= '0;
    end else if (insert && !full) begin
      occupancy <= occupancy + OCC_W'(1);
    end
  end

  // --- result register ---
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      hit        <= hit_now;
      read_value <= (req_kind == KIND_GET) ? link[ENTRIES].value : '0;
    end
  end

  // --- checks ---
  `LKVC_ASSERT_NOW(a_occ_count, 1'b1, $countones(valid_vec) == occupancy, "occupancy drift")
  `LKVC_ASSERT_NOW(a_one_match, state == ST_UPDATE, $onehot0(match_vec), "duplicate key")
  `LKVC_ASSERT_NEXT(a_done_after, state == ST_UPDATE, done, "missing result strobe")
  `LKVC_ASSERT_NEXT(a_take_start, accept, state == ST_LOOKUP, "request not started")

endmodule
